[src/mpbd_pkg.sv]
// Shared types and constants of the multi-press button decoder.
`default_nettype none

package mpbd_pkg;

    localparam int LINE_W  = 3;
    localparam int COUNT_W = 5;
    localparam int IDLE_W  = 8;
    localparam int ENTRY_W = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [IDLE_W-1:0]  IDLE_MAX  = 8'd255;

    localparam logic [15:0] TRIGGER_MODES_RESET = 16'hAAAA;
    localparam logic [7:0]  TIMEOUT_RESET       = 8'd20;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_LINES   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNTS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_MODES = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd3;

    // Trigger mode codes; anything at or above MODE_ANY accepts both levels.
    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_ANY  = 2'd2;

    // Result outcome codes.
    localparam logic [1:0] OUTCOME_NONE     = 2'd0;
    localparam logic [1:0] OUTCOME_MATCH    = 2'd1;
    localparam logic [1:0] OUTCOME_NO_MATCH = 2'd2;

    typedef struct packed {
        logic [7:0] edge_flags;
        logic [7:0] line_levels;
    } item_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic [ENTRY_W-1:0] entry_index;
        logic [LINE_W-1:0]  held_line;
        logic [COUNT_W-1:0] final_count;
    } result_t;

    typedef struct packed {
        logic               found;
        logic [ENTRY_W-1:0] index;
    } lookup_t;

endpackage

`default_nettype wire

[src/multi_press_button_decoder_unit.sv]
// Top level of the multi-press button decoder: config registers, hold state, tick logic.
//
// Usage: every item beat is one tick of a slow timebase, carrying an edge flag and the
// sampled level of each button line. A line with an edge whose trigger mode accepts its
// level counts as a press. Repeated presses of the held line raise the press count
// (saturating at 31); a press of another line starts a new hold with count 1. Once a hold
// has been idle for timeout_ticks ticks, the press table is searched and one result beat
// reports the matching entry, or that no entry matched.
// Every item beat yields exactly one result beat (outcome NONE on ordinary ticks).
// Throughput is one beat per cycle while item_stall is low; all tick work is one pass of
// small logic between the accepted beat and the result register (or the skid stage),
// with the hold state updated at the same edge.
// When the receiver stalls, the result register holds and one more beat is caught in a
// skid stage; item_stall rises only while that skid stage is occupied.
// Configuration writes (cfg_valid/cfg_ready, always ready) are registered when accepted
// and must be issued only while the block is idle.
// Reset (rst_n, asynchronous, active low) clears the hold state, empties the output
// buffer and loads the register defaults: table empty, every line on any level, timeout 20.
`default_nettype none

module multi_press_button_decoder_unit #(
    parameter int NUM_LINES   = 8,
    parameter int NUM_ENTRIES = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire mpbd_pkg::item_t                  item,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output mpbd_pkg::result_t                     result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mpbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]                      cfg_data
);

    // Configuration registers.
    logic [63:0] entry_lines_reg;
    logic [63:0] entry_counts_reg;
    logic [15:0] trigger_modes_reg;
    logic [7:0]  timeout_ticks_reg;

    // Hold state.
    logic                           hold_active_reg, hold_active_next;
    logic [mpbd_pkg::LINE_W-1:0]    hold_line_reg, hold_line_next;
    logic [mpbd_pkg::COUNT_W-1:0]   press_count_reg, press_count_next;
    logic [mpbd_pkg::IDLE_W-1:0]    idle_ticks_reg, idle_ticks_next;

    logic                         accept;
    logic [7:0]                   qual;
    logic [mpbd_pkg::LINE_W-1:0]  top_line;
    logic                         only_top;
    logic                         tick_active;
    logic [mpbd_pkg::LINE_W-1:0]  tick_line;
    logic [mpbd_pkg::COUNT_W-1:0] tick_count;
    logic [mpbd_pkg::IDLE_W-1:0]  tick_idle;
    logic                         timeout_hit;
    mpbd_pkg::lookup_t            hit;
    mpbd_pkg::result_t            step_result;
    logic                         buf_full;

    assign cfg_ready  = 1'b1;
    assign item_stall = buf_full;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_lines_reg   <= '0;
            entry_counts_reg  <= '0;
            trigger_modes_reg <= mpbd_pkg::TRIGGER_MODES_RESET;
            timeout_ticks_reg <= mpbd_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mpbd_pkg::CFG_ENTRY_LINES:   entry_lines_reg   <= cfg_data;
                mpbd_pkg::CFG_ENTRY_COUNTS:  entry_counts_reg  <= cfg_data;
                mpbd_pkg::CFG_TRIGGER_MODES: trigger_modes_reg <= cfg_data[15:0];
                mpbd_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Qualify each line on its own: edge seen and level accepted by its mode.
    always_comb
    begin
        qual = '0;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (trigger_modes_reg[2*i +: 2] >= mpbd_pkg::MODE_ANY)
            begin
                qual[i] = item.edge_flags[i];
            end
            else if (trigger_modes_reg[2*i +: 2] == mpbd_pkg::MODE_HIGH)
            begin
                qual[i] = item.edge_flags[i] && item.line_levels[i];
            end
            else
            begin
                qual[i] = item.edge_flags[i] && !item.line_levels[i];
            end
        end
    end

    // Presses applied in index order reduce to: the highest qualified line ends up held,
    // and only when it is the sole press on the already held line does the count advance.
    always_comb
    begin
        top_line = '0;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (qual[i])
            begin
                top_line = mpbd_pkg::LINE_W'(i);
            end
        end
        only_top = (qual & ~(8'b1 << top_line)) == 8'b0;
    end

    always_comb
    begin
        // Advance the idle timer of an active hold first.
        tick_idle = idle_ticks_reg;
        if (hold_active_reg && idle_ticks_reg != mpbd_pkg::IDLE_MAX)
        begin
            tick_idle = idle_ticks_reg + 1'b1;
        end
        tick_active = hold_active_reg;
        tick_line   = hold_line_reg;
        tick_count  = press_count_reg;
        if (qual != 8'b0)
        begin
            tick_idle   = '0;
            tick_active = 1'b1;
            tick_line   = top_line;
            if (only_top && hold_active_reg && hold_line_reg == top_line)
            begin
                if (press_count_reg != mpbd_pkg::COUNT_MAX)
                begin
                    tick_count = press_count_reg + 1'b1;
                end
            end
            else
            begin
                tick_count = mpbd_pkg::COUNT_W'(1);
            end
        end
        timeout_hit = tick_active && (tick_idle >= timeout_ticks_reg);
    end

    mpbd_lookup #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_lookup (
        .entry_lines  (entry_lines_reg),
        .entry_counts (entry_counts_reg),
        .hold_line    (tick_line),
        .press_count  (tick_count),
        .hit          (hit)
    );

    // Build the result and drop the hold when the sequence ends.
    always_comb
    begin
        step_result      = '0;
        hold_active_next = tick_active;
        hold_line_next   = tick_line;
        press_count_next = tick_count;
        idle_ticks_next  = tick_idle;
        if (timeout_hit)
        begin
            step_result.outcome     = hit.found ? mpbd_pkg::OUTCOME_MATCH
                                                : mpbd_pkg::OUTCOME_NO_MATCH;
            step_result.entry_index = hit.found ? hit.index : '0;
            step_result.held_line   = tick_line;
            step_result.final_count = tick_count;
            hold_active_next        = 1'b0;
            hold_line_next          = '0;
            press_count_next        = '0;
            idle_ticks_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_active_reg <= 1'b0;
            hold_line_reg   <= '0;
            press_count_reg <= '0;
            idle_ticks_reg  <= '0;
        end
        else if (accept)
        begin
            hold_active_reg <= hold_active_next;
            hold_line_reg   <= hold_line_next;
            press_count_reg <= press_count_next;
            idle_ticks_reg  <= idle_ticks_next;
        end
    end

    mpbd_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_valid   (accept),
        .push_data    (step_result),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_idle_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_active_reg |-> (press_count_reg == '0 && idle_ticks_reg == '0
                              && hold_line_reg == '0))
        else $error("hold state left over without an active hold");

    a_active_has_press: assert property (@(posedge clk) disable iff (!rst_n)
        hold_active_reg |-> press_count_reg != '0)
        else $error("active hold with zero press count");

    a_quiet_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.outcome == mpbd_pkg::OUTCOME_NONE)
        |-> (result.entry_index == '0 && result.held_line == '0
             && result.final_count == '0))
        else $error("quiet tick result carries nonzero fields");

    a_end_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && timeout_hit) |=> !hold_active_reg)
        else $error("hold still active after its sequence ended");

endmodule

`default_nettype wire

[src/mpbd_lookup.sv]
// Priority search of the press table for the first enabled matching entry.
`default_nettype none

module mpbd_lookup #(
    parameter int NUM_ENTRIES = 16
) (
    input  wire logic [63:0]                  entry_lines,
    input  wire logic [63:0]                  entry_counts,
    input  wire logic [mpbd_pkg::LINE_W-1:0]  hold_line,
    input  wire logic [mpbd_pkg::COUNT_W-1:0] press_count,
    output mpbd_pkg::lookup_t                 hit
);

    logic [3:0] ln;
    logic [3:0] cnt;

    // Scan from the top so the lowest matching entry is the last to land.
    always_comb
    begin
        hit = '0;
        ln  = '0;
        cnt = '0;
        for (int e = NUM_ENTRIES - 1; e >= 0; e--)
        begin
            ln  = entry_lines[4*e +: 4];
            cnt = entry_counts[4*e +: 4];
            if (cnt == 4'd0)
            begin
                cnt = 4'd1;
            end
            if (ln[3] && (ln[2:0] == hold_line) && ({1'b0, cnt} == press_count))
            begin
                hit.found = 1'b1;
                hit.index = mpbd_pkg::ENTRY_W'(e);
            end
        end
    end

endmodule

`default_nettype wire

[src/mpbd_out_buf.sv]
// Result register with a skid stage behind it.
`default_nettype none

module mpbd_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    input  wire mpbd_pkg::result_t push_data,
    output logic                   full,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output mpbd_pkg::result_t      result
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    mpbd_pkg::result_t out_data_reg, out_data_next;
    mpbd_pkg::result_t skid_data_reg, skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !result_stall)
        begin
            // Output slot frees up: drain the skid first, else take the new beat.
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push_valid;
                out_data_next  = push_data;
            end
        end
        else if (push_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while the output register is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push_valid)
        else $error("beat pushed while the skid stage is full");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !result_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid stage did not drain into the output register");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the multi-press button decoder unit.
`default_nettype none

module tb;

    // Stop starting random phases once this many ticks have been sent in total.
    localparam int TICK_TARGET  = 1650;
    // End the run when no beat moves on any channel for this many cycles.
    localparam int STUCK_LIMIT  = 1000;
    // Extra wait at the end of the run, for stray result beats.
    localparam int TAIL_CYCLES  = 4;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    mpbd_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    mpbd_pkg::result_t result;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [mpbd_pkg::CFG_INDEX_W-1:0] cfg_index = mpbd_pkg::CFG_ENTRY_LINES;
    logic [63:0]       cfg_data     = '0;

    multi_press_button_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Register values as the decoder sees them, updated at each write beat.
    logic [63:0] tbl_lines   = '0;
    logic [63:0] tbl_counts  = '0;
    logic [15:0] mode_bits   = mpbd_pkg::TRIGGER_MODES_RESET;
    logic [7:0]  timeout_lim = mpbd_pkg::TIMEOUT_RESET;

    // Hold state of the decoder, advanced once per accepted tick.
    logic                         hold_on  = 1'b0;
    logic [mpbd_pkg::LINE_W-1:0]  hold_ln  = '0;
    logic [mpbd_pkg::COUNT_W-1:0] hold_cnt = '0;
    logic [mpbd_pkg::IDLE_W-1:0]  idle_cnt = '0;

    // Settings of the running phase, used to shape the stimulus.
    logic [63:0] phase_lines   = '0;
    logic [63:0] phase_counts  = '0;
    logic [15:0] phase_modes   = mpbd_pkg::TRIGGER_MODES_RESET;
    logic [7:0]  phase_timeout = mpbd_pkg::TIMEOUT_RESET;

    mpbd_pkg::result_t predicted_reports[$];
    mpbd_pkg::result_t want;
    int unsigned mismatches  = 0;
    int unsigned ticks_sent  = 0;
    bit          quiet_src   = 1'b0;
    bit          quiet_sink  = 1'b0;
    int          stall_left  = 0;
    int          stuck_cycles;

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // Advance the hold state by one tick and return the report it produces.
    function automatic mpbd_pkg::result_t decode_tick(input mpbd_pkg::item_t beat);
        mpbd_pkg::result_t  rep;
        logic [1:0]         mode;
        logic               lvl;
        logic [3:0]         ent_line;
        logic [3:0]         ent_count;
        logic               found;
        int                 i;
        int                 e;
        rep = '0;
        rep.outcome = mpbd_pkg::OUTCOME_NONE;
        if (hold_on && idle_cnt != mpbd_pkg::IDLE_MAX)
            idle_cnt = idle_cnt + 1'b1;
        // Scan lines in index order; a later qualified line overrides the hold.
        for (i = 0; i < 8; i++)
        begin
            mode = mode_bits[2*i +: 2];
            lvl  = beat.line_levels[i];
            if (beat.edge_flags[i] &&
                !(mode == mpbd_pkg::MODE_LOW && lvl) && !(mode == mpbd_pkg::MODE_HIGH && !lvl))
            begin
                if (hold_on && hold_ln == i)
                begin
                    if (hold_cnt != mpbd_pkg::COUNT_MAX)
                        hold_cnt = hold_cnt + 1'b1;
                end
                else
                begin
                    hold_on  = 1'b1;
                    hold_ln  = i[2:0];
                    hold_cnt = mpbd_pkg::COUNT_W'(1);
                end
                idle_cnt = '0;
            end
        end
        // Timeout reached: look up the first enabled entry on this line and count.
        if (hold_on && idle_cnt >= timeout_lim)
        begin
            found = 1'b0;
            rep.outcome     = mpbd_pkg::OUTCOME_NO_MATCH;
            rep.held_line   = hold_ln;
            rep.final_count = hold_cnt;
            for (e = 0; e < 16; e++)
            begin
                ent_line  = tbl_lines[4*e +: 4];
                ent_count = tbl_counts[4*e +: 4];
                if (ent_count == 4'd0)
                    ent_count = 4'd1;
                if (!found && ent_line[3] && ent_line[2:0] == hold_ln &&
                    {1'b0, ent_count} == hold_cnt)
                begin
                    found           = 1'b1;
                    rep.outcome     = mpbd_pkg::OUTCOME_MATCH;
                    rep.entry_index = e[3:0];
                end
            end
            hold_on  = 1'b0;
            hold_ln  = '0;
            hold_cnt = '0;
            idle_cnt = '0;
        end
        return rep;
    endfunction

    task automatic compare_field(input string fname, input int unsigned exp_v,
                                 input int unsigned got_v);
        if (exp_v != got_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, fname, exp_v, got_v);
        end
    endtask

    // Track register writes, check each result beat against the oldest
    // prediction, and predict the report of each accepted tick.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mpbd_pkg::CFG_ENTRY_LINES:   tbl_lines   = cfg_data;
                    mpbd_pkg::CFG_ENTRY_COUNTS:  tbl_counts  = cfg_data;
                    mpbd_pkg::CFG_TRIGGER_MODES: mode_bits   = cfg_data[15:0];
                    mpbd_pkg::CFG_TIMEOUT_TICKS: timeout_lim = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (predicted_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with no tick outstanding, expected none actual %h",
                             $time, result);
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    compare_field("outcome",     want.outcome,     result.outcome);
                    compare_field("entry_index", want.entry_index, result.entry_index);
                    compare_field("held_line",   want.held_line,   result.held_line);
                    compare_field("final_count", want.final_count, result.final_count);
                end
            end
            if (item_valid && !item_stall)
                predicted_reports.push_back(decode_tick(item));
        end
    end

    // Receiver: after each accepted result beat, draw a stall (none if quiet_sink).
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                if (stall_left == 0)
                    result_stall <= 1'b0;
            end
            else if (result_valid && !result_stall)
            begin
                stall_left = draw_gap(quiet_sink);
                if (stall_left != 0)
                    result_stall <= 1'b1;
            end
        end
    end

    // Watchdog: give up when no beat moves on any channel for too long.
    initial
    begin
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Send one tick: idle for a drawn gap, then hold the beat until accepted.
    // Entered and left at a rising edge.
    task automatic send_tick(input logic [7:0] edges, input logic [7:0] levels);
        mpbd_pkg::item_t beat;
        int              gap;
        beat.edge_flags  = edges;
        beat.line_levels = levels;
        gap = draw_gap(quiet_src);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        // Stall settles after the edge; the beat moves at the next edge it is low.
        @(negedge clk);
        while (item_stall)
            @(negedge clk);
        @(posedge clk);
        ticks_sent++;
    endtask

    // Drop valid and wait until every predicted report has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (predicted_reports.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; valid stays high so writes can follow back to back.
    task automatic write_reg(input logic [mpbd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Reprogram all four registers once every predicted report has come back.
    task automatic apply_config(input logic [63:0] lines, input logic [63:0] counts,
                                input logic [15:0] modes, input logic [7:0] ticks);
        drain_results();
        phase_lines   = lines;
        phase_counts  = counts;
        phase_modes   = modes;
        phase_timeout = ticks;
        write_reg(mpbd_pkg::CFG_ENTRY_LINES,   lines);
        write_reg(mpbd_pkg::CFG_ENTRY_COUNTS,  counts);
        write_reg(mpbd_pkg::CFG_TRIGGER_MODES, {48'h0, modes});
        write_reg(mpbd_pkg::CFG_TIMEOUT_TICKS, {56'h0, ticks});
        cfg_valid <= 1'b0;
    endtask

    // Pick a level that the phase's trigger mode accepts on this line.
    function automatic logic qualifying_level(input int line);
        logic [1:0] mode;
        mode = phase_modes[2*line +: 2];
        if (mode == mpbd_pkg::MODE_LOW)
            return 1'b0;
        if (mode == mpbd_pkg::MODE_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // Press one line a number of times with short pauses below the timeout,
    // then go quiet long enough for the hold to time out.
    task automatic press_sequence(input int line, input int presses);
        logic [7:0] ed;
        logic [7:0] lv;
        int         k;
        int         max_pause;
        max_pause = (phase_timeout > 4) ? 3 :
                    ((phase_timeout == 0) ? 0 : int'(phase_timeout) - 1);
        for (k = 0; k < presses; k++)
        begin
            lv       = 8'($urandom_range(0, 255));
            lv[line] = qualifying_level(line);
            ed       = 8'h00;
            ed[line] = 1'b1;
            send_tick(ed, lv);
            if (k != presses - 1)
                repeat ($urandom_range(0, max_pause))
                    send_tick(8'h00, 8'($urandom_range(0, 255)));
        end
        repeat (phase_timeout + $urandom_range(0, 2))
            send_tick(8'h00, 8'($urandom_range(0, 255)));
    endtask

    // Hand-picked ticks: every trigger mode, disabled and duplicate entries,
    // a zero table count, several lines in one tick, and a zero timeout.
    task automatic test_directed_cases();
        // entry 0: line 0 x1, entry 1: line 7 x15, entry 2: line 3 count zero,
        // entry 3: disabled line 5 x2, entry 15: line 5 x2
        apply_config(64'hD000_0000_0000_5BF8, 64'h2000_0000_0000_20F1,
                     {mpbd_pkg::MODE_ANY, mpbd_pkg::MODE_ANY, mpbd_pkg::MODE_ANY,
                      mpbd_pkg::MODE_ANY, mpbd_pkg::MODE_ANY,
                      mpbd_pkg::MODE_ANY | mpbd_pkg::MODE_HIGH, mpbd_pkg::MODE_HIGH,
                      mpbd_pkg::MODE_LOW}, 8'd1);
        send_tick(8'h01, 8'h00);    // low-mode line pressed low
        send_tick(8'h00, 8'hFF);    // times out: match on entry 0
        send_tick(8'h01, 8'h01);    // low-mode line at high level: ignored
        send_tick(8'h02, 8'h02);    // high-mode line pressed high
        send_tick(8'h02, 8'h00);    // high-mode line low: ignored, hold times out
        send_tick(8'hFF, 8'hFF);    // every line at once: line 7 wins
        send_tick(8'h80, 8'h00);    // second press of line 7
        send_tick(8'h00, 8'h00);    // no entry for line 7 twice
        send_tick(8'h08, 8'h00);    // line 3 once
        send_tick(8'h00, 8'h00);    // table count of zero acts as one
        send_tick(8'h20, 8'h20);
        send_tick(8'h20, 8'h00);
        send_tick(8'h00, 8'h00);    // disabled entry skipped, last entry matches
        send_tick(8'h04, 8'hFB);    // mode 3 accepts a low level
        send_tick(8'h08, 8'h04);    // another line takes over the hold
        send_tick(8'h00, 8'h00);
        apply_config(64'hD000_0000_0000_5BF8, 64'h2000_0000_0000_20F1,
                     {mpbd_pkg::MODE_ANY, mpbd_pkg::MODE_ANY, mpbd_pkg::MODE_ANY,
                      mpbd_pkg::MODE_ANY, mpbd_pkg::MODE_ANY,
                      mpbd_pkg::MODE_ANY | mpbd_pkg::MODE_HIGH, mpbd_pkg::MODE_HIGH,
                      mpbd_pkg::MODE_LOW}, 8'd0);
        send_tick(8'h01, 8'h00);    // zero timeout ends the hold on the press itself
        send_tick(8'h03, 8'h02);    // two qualified lines, the higher one reports
        send_tick(8'h00, 8'h00);
        send_tick(8'hFF, 8'h00);
    endtask

    // Hold the sender until every report is back in the middle of a hold;
    // the hold must survive since only ticks advance the timer.
    task automatic test_hold_across_pause();
        apply_config(64'h0000_0000_0000_000C, 64'h0000_0000_0000_0004,
                     mpbd_pkg::TRIGGER_MODES_RESET, 8'd6);
        send_tick(8'h10, 8'($urandom_range(0, 255)));
        send_tick(8'h10, 8'($urandom_range(0, 255)));
        drain_results();
        send_tick(8'h10, 8'($urandom_range(0, 255)));
        send_tick(8'h10, 8'($urandom_range(0, 255)));
        repeat (6) send_tick(8'h00, 8'($urandom_range(0, 255)));
    endtask

    // Phases of random settings; most traffic is well-formed press sequences,
    // many aimed at table entries, the rest random ticks.
    task automatic test_random_phases();
        logic [63:0] lines;
        logic [63:0] counts;
        logic [15:0] modes;
        logic [7:0]  ticks;
        int          phase;
        int          n;
        int          pick;
        int          line;
        int          presses;
        int unsigned phase_start;
        bit          wide;
        phase = 0;
        while (ticks_sent < TICK_TARGET)
        begin
            quiet_src  = ($urandom_range(0, 3) == 0);
            quiet_sink = ($urandom_range(0, 3) == 0);
            if (phase == 0)
            begin
                // Longest timeout, full table on line 7 with count 15.
                apply_config('1, '1, 16'hFFFF, 8'd255);
                press_sequence(7, 15);
            end
            else
            begin
                wide = ($urandom_range(0, 3) == 0);
                for (n = 0; n < 16; n++)
                begin
                    lines[4*n+3]     = ($urandom_range(0, 4) != 0);
                    lines[4*n +: 3]  = 3'($urandom_range(0, 7));
                    counts[4*n +: 4] = 4'(wide ? $urandom_range(0, 15) : $urandom_range(0, 4));
                end
                pick = $urandom_range(0, 5);
                modes = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'h5555 :
                        (pick == 2) ? 16'hFFFF : 16'($urandom_range(0, 65535));
                ticks = 8'(($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(1, 12));
                if (phase == 1)
                begin
                    lines  = '0;
                    counts = '0;
                    modes  = 16'h0000;
                    ticks  = 8'd1;
                end
                else if (phase == 2)
                begin
                    modes = 16'h5555;
                    ticks = 8'd0;
                end
                apply_config(lines, counts, modes, ticks);
                phase_start = ticks_sent;
                while (ticks_sent - phase_start < 150)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 2)
                    begin
                        repeat ($urandom_range(1, 4))
                            send_tick(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        if (pick < 7)
                        begin
                            // Aim at a table entry so that lookups can hit.
                            n       = $urandom_range(0, 15);
                            line    = int'(phase_lines[4*n +: 3]);
                            presses = int'(phase_counts[4*n +: 4]);
                            if (presses == 0)
                                presses = 1;
                        end
                        else
                        begin
                            line    = $urandom_range(0, 7);
                            presses = (pick == 9) ? $urandom_range(16, 40)
                                                  : $urandom_range(1, 6);
                        end
                        press_sequence(line, presses);
                    end
                end
            end
            phase++;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_hold_across_pause();
        test_random_phases();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
src/mpbd_pkg.sv
src/mpbd_lookup.sv
src/mpbd_out_buf.sv
src/multi_press_button_decoder_unit.sv
tb/tb.sv
